>>> rtl/lds_pkg.sv
// Shared types, constants and fixed-point helpers for the 3x3 LDL^T solver.
// Used by lds_front, lds_div, lds_back and ldlt_solve_3x3_top; no dependencies.
`timescale 1ns / 1ps
package lds_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int MAG_W     = PROD_BITS + 1;
  // dividend is |a| << FRAC_BITS; one quotient bit per divider stage
  localparam int QB        = WORD_BITS + FRAC_BITS;
  localparam int DIV_LAT   = QB + 3;
  localparam int DIV_LANES = 3;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
  localparam int NST      = 18;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef word_t [DIV_LANES-1:0] lanes_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t WORD_ONE = word_t'(1);

  localparam logic [MAG_W-1:0] RND_HALF = MAG_W'(1) << (FRAC_BITS - 1);
  localparam logic [MAG_W-1:0] MAG_NEG  = MAG_W'(1) << (WORD_BITS - 1);
  localparam logic [MAG_W-1:0] MAG_POS  = MAG_NEG - MAG_W'(1);
  localparam logic [QB:0]      QLIM_NEG = (QB+1)'(1) << (WORD_BITS - 1);
  localparam logic [QB:0]      QLIM_POS = QLIM_NEG - (QB+1)'(1);

  // one input item as it leaves the front queue
  typedef struct packed {
    word_t m00;
    word_t m10;
    word_t m20;
    word_t m11;
    word_t m21;
    word_t m22;
    word_t r0;
    word_t r1;
    word_t r2;
    logic  d1_zero;
  } fe_item_t;

  // everything live in the back pipeline
  typedef struct packed {
    logic  v;
    logic  f;
    word_t m11;
    word_t m21;
    word_t m22;
    word_t r0;
    word_t r1;
    word_t r2;
    word_t d1;
    word_t d2;
    word_t d3;
    word_t l21;
    word_t l31;
    word_t l32;
    word_t z1;
    word_t z2;
    word_t x0;
    word_t x1;
    word_t x2;
    word_t y2;
    word_t t3;
    word_t y3;
    word_t ta;
    word_t tb;
    word_t tc;
    word_t te;
    word_t tg;
    word_t th;
    word_t ts;
    prod_t p0;
    prod_t p1;
    prod_t p2;
    prod_t p3;
    prod_t p4;
  } ctx_t;

  typedef struct packed {
    logic              neg;
    logic [WORD_BITS-1:0] den;
    logic [WORD_BITS-1:0] rem;
    logic [QB-1:0]     nq;
  } div_lane_t;

  typedef struct packed {
    word_t sol0;
    word_t sol1;
    word_t sol2;
    logic  fault;
  } res_t;

  function automatic logic [WORD_BITS-1:0] mag_w(word_t a);
    return a[WORD_BITS-1] ? -a : a;
  endfunction

  function automatic prod_t fx_prod(word_t a, word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // shift right FRAC_BITS, round half away from zero, saturate
  function automatic word_t fx_round(prod_t p);
    logic                 neg;
    logic [MAG_W-1:0]     mag;
    logic [WORD_BITS-1:0] w;
    neg = p[PROD_BITS-1];
    mag = {1'b0, (neg ? -p : p)};
    mag = (mag + RND_HALF) >> FRAC_BITS;
    if (neg && mag > MAG_NEG) mag = MAG_NEG;
    if (!neg && mag > MAG_POS) mag = MAG_POS;
    w = mag[WORD_BITS-1:0];
    return neg ? word_t'(-w) : word_t'(w);
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return s[WORD_BITS-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return s[WORD_BITS-1:0];
  endfunction

endpackage

>>> rtl/lds_front.sv
// Front end: accepts items, flags a zero first pivot, and queues them for the back end.
// Depends on lds_pkg.
`timescale 1ns / 1ps
module lds_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  lds_pkg::word_t   in_m_00,
  input  lds_pkg::word_t   in_m_10,
  input  lds_pkg::word_t   in_m_20,
  input  lds_pkg::word_t   in_m_11,
  input  lds_pkg::word_t   in_m_21,
  input  lds_pkg::word_t   in_m_22,
  input  lds_pkg::word_t   in_rhs_0,
  input  lds_pkg::word_t   in_rhs_1,
  input  lds_pkg::word_t   in_rhs_2,
  output logic             fe_valid_o,
  output lds_pkg::fe_item_t fe_item_o,
  input  logic             fe_pop_i
);

  lds_pkg::fe_item_t             mem_r [lds_pkg::IQ_DEPTH];
  logic [lds_pkg::IQ_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [lds_pkg::IQ_CW-1:0]     cnt_r;
  logic                          enq;
  lds_pkg::fe_item_t             item;

  assign full = (cnt_r == lds_pkg::IQ_CW'(lds_pkg::IQ_DEPTH));
  assign enq  = push && !full;
  assign fe_valid_o = (cnt_r != '0);
  assign fe_item_o  = mem_r[rd_ptr_r];

  always_comb begin
    item.m00 = in_m_00;
    item.m10 = in_m_10;
    item.m20 = in_m_20;
    item.m11 = in_m_11;
    item.m21 = in_m_21;
    item.m22 = in_m_22;
    item.r0  = in_rhs_0;
    item.r1  = in_rhs_1;
    item.r2  = in_rhs_2;
    item.d1_zero = (in_m_00 == '0);
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (fe_pop_i) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + lds_pkg::IQ_CW'(enq) - lds_pkg::IQ_CW'(fe_pop_i);
    end
  end

`ifndef ASSERT_OFF
  a_iq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lds_pkg::IQ_CW'(lds_pkg::IQ_DEPTH))
    else $error("input queue count out of range");
  a_iq_pop: assert property (@(posedge clk) disable iff (!rst_n)
    fe_pop_i |-> fe_valid_o)
    else $error("back end popped an empty input queue");
`endif

endmodule

>>> rtl/lds_div.sv
// Pipelined signed fixed-point divider, three lanes, one quotient bit per stage.
// Carries a pipeline context alongside; depends on lds_pkg.
`timescale 1ns / 1ps
module lds_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  lds_pkg::ctx_t   ctx_i,
  input  lds_pkg::lanes_t num_i,
  input  lds_pkg::lanes_t den_i,
  output lds_pkg::ctx_t   ctx_o,
  output lds_pkg::lanes_t quo_o
);

  lds_pkg::ctx_t ctx_r [lds_pkg::DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lds_pkg::DIV_LAT; i++) ctx_r[i] <= '0;
    end else if (en) begin
      ctx_r[0] <= ctx_i;
      for (int i = 1; i < lds_pkg::DIV_LAT; i++) ctx_r[i] <= ctx_r[i-1];
    end
  end

  assign ctx_o = ctx_r[lds_pkg::DIV_LAT-1];

  for (genvar j = 0; j < lds_pkg::DIV_LANES; j++) begin : g_lane
    lds_pkg::div_lane_t            ln_r   [lds_pkg::QB+1];
    lds_pkg::div_lane_t            ln_nxt [lds_pkg::QB+1];
    logic [lds_pkg::QB:0]          q_r;
    logic                          qneg_r;
    lds_pkg::word_t                quo_r;
    lds_pkg::word_t                quo_nxt;
    logic                          up;

    always_comb begin
      logic [lds_pkg::WORD_BITS:0] trial;
      ln_nxt[0].neg = num_i[j][lds_pkg::WORD_BITS-1] ^ den_i[j][lds_pkg::WORD_BITS-1];
      ln_nxt[0].den = lds_pkg::mag_w(den_i[j]);
      ln_nxt[0].rem = '0;
      ln_nxt[0].nq  = {lds_pkg::mag_w(num_i[j]), {lds_pkg::FRAC_BITS{1'b0}}};
      for (int k = 1; k <= lds_pkg::QB; k++) begin
        ln_nxt[k] = ln_r[k-1];
        trial = {ln_r[k-1].rem, ln_r[k-1].nq[lds_pkg::QB-1]};
        if (trial >= {1'b0, ln_r[k-1].den}) begin
          trial = trial - {1'b0, ln_r[k-1].den};
          ln_nxt[k].nq = {ln_r[k-1].nq[lds_pkg::QB-2:0], 1'b1};
        end else begin
          ln_nxt[k].nq = {ln_r[k-1].nq[lds_pkg::QB-2:0], 1'b0};
        end
        ln_nxt[k].rem = trial[lds_pkg::WORD_BITS-1:0];
      end
    end

    // round half away from zero: bump when 2*rem >= den
    assign up = ({ln_r[lds_pkg::QB].rem, 1'b0} >= {1'b0, ln_r[lds_pkg::QB].den});

    always_comb begin
      logic [lds_pkg::QB:0]          qs;
      logic [lds_pkg::WORD_BITS-1:0] w;
      qs = q_r;
      if (qneg_r && qs > lds_pkg::QLIM_NEG) qs = lds_pkg::QLIM_NEG;
      if (!qneg_r && qs > lds_pkg::QLIM_POS) qs = lds_pkg::QLIM_POS;
      w = qs[lds_pkg::WORD_BITS-1:0];
      quo_nxt = qneg_r ? lds_pkg::word_t'(-w) : lds_pkg::word_t'(w);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k <= lds_pkg::QB; k++) ln_r[k] <= ln_nxt[k];
        q_r    <= {1'b0, ln_r[lds_pkg::QB].nq} + (lds_pkg::QB+1)'(up);
        qneg_r <= ln_r[lds_pkg::QB].neg;
        quo_r  <= quo_nxt;
      end
    end

    assign quo_o[j] = quo_r;
  end

endmodule

>>> rtl/lds_back.sv
// Back end: factor, substitute and divide in a fixed pipeline, then a two-entry result queue.
// Depends on lds_pkg and lds_div.
`timescale 1ns / 1ps
module lds_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fe_valid_i,
  input  lds_pkg::fe_item_t fe_item_i,
  output logic              fe_pop_o,
  output logic              empty,
  input  logic              pop,
  output lds_pkg::word_t    out_sol_0,
  output lds_pkg::word_t    out_sol_1,
  output lds_pkg::word_t    out_sol_2,
  output logic              out_pivot_fault
);

  logic                       adv;
  lds_pkg::ctx_t              st_r   [1:lds_pkg::NST];
  lds_pkg::ctx_t              st_nxt [1:lds_pkg::NST];
  lds_pkg::ctx_t              ca_in, ca_out, cb_in, cb_out, cc_in, cc_out;
  lds_pkg::lanes_t            na, da, qa, nb, db, qb, nc, dc, qc;

  lds_pkg::res_t              oq_r [lds_pkg::OQ_DEPTH];
  logic [lds_pkg::OQ_AW-1:0]  oq_wr_r, oq_rd_r;
  logic [lds_pkg::OQ_CW-1:0]  oq_cnt_r;
  logic                       oq_push, oq_pop;
  lds_pkg::res_t              res, head;

  // whole pipeline moves while the result queue has a free slot
  assign adv      = (oq_cnt_r != lds_pkg::OQ_CW'(lds_pkg::OQ_DEPTH));
  assign fe_pop_o = adv && fe_valid_i;

  always_comb begin
    ca_in     = '0;
    ca_in.v   = fe_pop_o;
    ca_in.f   = fe_item_i.d1_zero;
    ca_in.m11 = fe_item_i.m11;
    ca_in.m21 = fe_item_i.m21;
    ca_in.m22 = fe_item_i.m22;
    ca_in.r0  = fe_item_i.r0;
    ca_in.r1  = fe_item_i.r1;
    ca_in.r2  = fe_item_i.r2;
    ca_in.d1  = fe_item_i.m00;
    na = {fe_item_i.r0, fe_item_i.m20, fe_item_i.m10};
    da = {fe_item_i.m00, fe_item_i.m00, fe_item_i.m00};
  end

  lds_div u_div_a (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .ctx_i(ca_in), .num_i(na), .den_i(da), .ctx_o(ca_out), .quo_o(qa)
  );

  always_comb begin
    cb_in   = st_r[5];
    cb_in.f = st_r[5].f || (st_r[5].d2 == '0);
    nb = {lds_pkg::word_t'(0), st_r[5].y2, st_r[5].tb};
    db = {lds_pkg::WORD_ONE, st_r[5].d2, st_r[5].d2};
  end

  lds_div u_div_b (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .ctx_i(cb_in), .num_i(nb), .den_i(db), .ctx_o(cb_out), .quo_o(qb)
  );

  always_comb begin
    cc_in   = st_r[11];
    cc_in.f = st_r[11].f || (st_r[11].d3 == '0);
    nc = {lds_pkg::word_t'(0), lds_pkg::word_t'(0), st_r[11].y3};
    dc = {lds_pkg::WORD_ONE, lds_pkg::WORD_ONE, st_r[11].d3};
  end

  lds_div u_div_c (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .ctx_i(cc_in), .num_i(nc), .den_i(dc), .ctx_o(cc_out), .quo_o(qc)
  );

  always_comb begin
    // first level of products after L21, L31, z1
    st_nxt[1]     = ca_out;
    st_nxt[1].l21 = qa[0];
    st_nxt[1].l31 = qa[1];
    st_nxt[1].z1  = qa[2];
    st_nxt[1].p0  = lds_pkg::fx_prod(qa[0], qa[0]);
    st_nxt[1].p1  = lds_pkg::fx_prod(qa[0], qa[1]);
    st_nxt[1].p2  = lds_pkg::fx_prod(qa[1], qa[1]);
    st_nxt[1].p3  = lds_pkg::fx_prod(qa[0], ca_out.r0);
    st_nxt[1].p4  = lds_pkg::fx_prod(qa[1], ca_out.r0);

    st_nxt[2]    = st_r[1];
    st_nxt[2].ta = lds_pkg::fx_round(st_r[1].p0);
    st_nxt[2].tb = lds_pkg::fx_round(st_r[1].p1);
    st_nxt[2].tc = lds_pkg::fx_round(st_r[1].p2);
    st_nxt[2].tg = lds_pkg::fx_round(st_r[1].p3);
    st_nxt[2].te = lds_pkg::fx_round(st_r[1].p4);

    st_nxt[3]    = st_r[2];
    st_nxt[3].p0 = lds_pkg::fx_prod(st_r[2].ta, st_r[2].d1);
    st_nxt[3].p1 = lds_pkg::fx_prod(st_r[2].tb, st_r[2].d1);
    st_nxt[3].p2 = lds_pkg::fx_prod(st_r[2].tc, st_r[2].d1);
    st_nxt[3].y2 = lds_pkg::sat_sub(st_r[2].r1, st_r[2].tg);
    st_nxt[3].t3 = lds_pkg::sat_sub(st_r[2].r2, st_r[2].te);

    st_nxt[4]    = st_r[3];
    st_nxt[4].ta = lds_pkg::fx_round(st_r[3].p0);
    st_nxt[4].tb = lds_pkg::fx_round(st_r[3].p1);
    st_nxt[4].tc = lds_pkg::fx_round(st_r[3].p2);

    // D2 and the numerator of L32
    st_nxt[5]    = st_r[4];
    st_nxt[5].d2 = lds_pkg::sat_sub(st_r[4].m11, st_r[4].ta);
    st_nxt[5].tb = lds_pkg::sat_sub(st_r[4].m21, st_r[4].tb);

    st_nxt[6]     = cb_out;
    st_nxt[6].l32 = qb[0];
    st_nxt[6].z2  = qb[1];
    st_nxt[6].p0  = lds_pkg::fx_prod(qb[0], qb[0]);
    st_nxt[6].p1  = lds_pkg::fx_prod(qb[0], cb_out.y2);

    st_nxt[7]    = st_r[6];
    st_nxt[7].te = lds_pkg::fx_round(st_r[6].p0);
    st_nxt[7].tg = lds_pkg::fx_round(st_r[6].p1);

    st_nxt[8]    = st_r[7];
    st_nxt[8].p0 = lds_pkg::fx_prod(st_r[7].te, st_r[7].d2);
    st_nxt[8].y3 = lds_pkg::sat_sub(st_r[7].t3, st_r[7].tg);

    st_nxt[9]    = st_r[8];
    st_nxt[9].th = lds_pkg::fx_round(st_r[8].p0);

    st_nxt[10]    = st_r[9];
    st_nxt[10].ts = lds_pkg::sat_add(st_r[9].tc, st_r[9].th);

    st_nxt[11]    = st_r[10];
    st_nxt[11].d3 = lds_pkg::sat_sub(st_r[10].m22, st_r[10].ts);

    // back substitution
    st_nxt[12]    = cc_out;
    st_nxt[12].x2 = qc[0];
    st_nxt[12].p0 = lds_pkg::fx_prod(cc_out.l32, qc[0]);

    st_nxt[13]    = st_r[12];
    st_nxt[13].te = lds_pkg::fx_round(st_r[12].p0);

    st_nxt[14]    = st_r[13];
    st_nxt[14].x1 = lds_pkg::sat_sub(st_r[13].z2, st_r[13].te);

    st_nxt[15]    = st_r[14];
    st_nxt[15].p0 = lds_pkg::fx_prod(st_r[14].l21, st_r[14].x1);
    st_nxt[15].p1 = lds_pkg::fx_prod(st_r[14].l31, st_r[14].x2);

    st_nxt[16]    = st_r[15];
    st_nxt[16].ta = lds_pkg::fx_round(st_r[15].p0);
    st_nxt[16].tb = lds_pkg::fx_round(st_r[15].p1);

    st_nxt[17]    = st_r[16];
    st_nxt[17].ts = lds_pkg::sat_sub(st_r[16].z1, st_r[16].ta);

    st_nxt[18]    = st_r[17];
    st_nxt[18].x0 = lds_pkg::sat_sub(st_r[17].ts, st_r[17].tb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= lds_pkg::NST; i++) st_r[i] <= '0;
    end else if (adv) begin
      for (int i = 1; i <= lds_pkg::NST; i++) st_r[i] <= st_nxt[i];
    end
  end

  // a zero pivot forces the solution to zero
  always_comb begin
    res.fault = st_r[lds_pkg::NST].f;
    res.sol0  = st_r[lds_pkg::NST].f ? '0 : st_r[lds_pkg::NST].x0;
    res.sol1  = st_r[lds_pkg::NST].f ? '0 : st_r[lds_pkg::NST].x1;
    res.sol2  = st_r[lds_pkg::NST].f ? '0 : st_r[lds_pkg::NST].x2;
  end

  assign oq_push = adv && st_r[lds_pkg::NST].v;
  assign empty   = (oq_cnt_r == '0);
  assign oq_pop  = pop && !empty;
  assign head    = oq_r[oq_rd_r];

  assign out_sol_0       = head.sol0;
  assign out_sol_1       = head.sol1;
  assign out_sol_2       = head.sol2;
  assign out_pivot_fault = head.fault;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) oq_wr_r <= oq_wr_r + 1'b1;
      if (oq_pop) oq_rd_r <= oq_rd_r + 1'b1;
      oq_cnt_r <= oq_cnt_r + lds_pkg::OQ_CW'(oq_push) - lds_pkg::OQ_CW'(oq_pop);
    end
  end

`ifndef ASSERT_OFF
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= lds_pkg::OQ_CW'(lds_pkg::OQ_DEPTH))
    else $error("result queue overflow");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_pivot_fault) |->
      (out_sol_0 == '0 && out_sol_1 == '0 && out_sol_2 == '0))
    else $error("faulted item carries a nonzero solution");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");
`endif

endmodule

>>> rtl/ldlt_solve_3x3_top.sv
// Top level of the 3x3 symmetric LDL^T solver: input queue front end and pipelined back end.
// Depends on lds_pkg, lds_front, lds_back.
`timescale 1ns / 1ps
// Solves M x = r for a symmetric 3x3 matrix in signed Q16.16. Both sides are queues: push an
// item while full is low, pop a result while empty is low; one result comes back per item, in
// order. The block accepts one item every cycle and keeps that rate as long as results are
// popped. The arithmetic runs in Q16.16 through three chained dividers that resolve one
// quotient bit per stage: first L21, L31 and y1/D1, then L32 and y2/D2, then y3/D3. When pop
// stalls and the two-entry result queue fills, the whole back pipeline holds, and a four-deep
// input queue absorbs items until full rises. A zero pivot sets pivot_fault and returns an
// all-zero solution.
module ldlt_solve_3x3_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  lds_pkg::word_t in_m_00,
  input  lds_pkg::word_t in_m_10,
  input  lds_pkg::word_t in_m_20,
  input  lds_pkg::word_t in_m_11,
  input  lds_pkg::word_t in_m_21,
  input  lds_pkg::word_t in_m_22,
  input  lds_pkg::word_t in_rhs_0,
  input  lds_pkg::word_t in_rhs_1,
  input  lds_pkg::word_t in_rhs_2,
  output logic           empty,
  input  logic           pop,
  output lds_pkg::word_t out_sol_0,
  output lds_pkg::word_t out_sol_1,
  output lds_pkg::word_t out_sol_2,
  output logic           out_pivot_fault
);

  logic              fe_valid;
  logic              fe_pop;
  lds_pkg::fe_item_t fe_item;

  lds_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_m_00(in_m_00), .in_m_10(in_m_10), .in_m_20(in_m_20),
    .in_m_11(in_m_11), .in_m_21(in_m_21), .in_m_22(in_m_22),
    .in_rhs_0(in_rhs_0), .in_rhs_1(in_rhs_1), .in_rhs_2(in_rhs_2),
    .fe_valid_o(fe_valid), .fe_item_o(fe_item), .fe_pop_i(fe_pop)
  );

  lds_back u_back (
    .clk(clk), .rst_n(rst_n),
    .fe_valid_i(fe_valid), .fe_item_i(fe_item), .fe_pop_o(fe_pop),
    .empty(empty), .pop(pop),
    .out_sol_0(out_sol_0), .out_sol_1(out_sol_1), .out_sol_2(out_sol_2),
    .out_pivot_fault(out_pivot_fault)
  );

endmodule

>>> tb/ldlt_solve_3x3_top_tb.sv
// Self-checking testbench for the 3x3 LDL^T solver: directed and random systems, queue
// handshakes on both sides with random idling, checked against an in-bench Q16.16 predictor.
// Depends on lds_pkg and ldlt_solve_3x3_top.
`timescale 1ns / 1ps
module ldlt_solve_3x3_top_tb;

  typedef struct {
    lds_pkg::word_t s0, s1, s2;
    logic           fault;
  } solution_t;

  class solution_board;
    solution_t pending[$];
    int        errors;

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint add_s(longint a, longint b);
      return clamp(a + b);
    endfunction

    function longint sub_s(longint a, longint b);
      return clamp(a - b);
    endfunction

    function longint from_mag(bit neg, logic [127:0] q);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function longint mul_q(longint a, longint b);
      logic [127:0] p;
      bit           neg;
      neg = (a < 0) != (b < 0);
      p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
      p = (p + 128'h8000) >> lds_pkg::FRAC_BITS;
      return from_mag(neg, p);
    endfunction

    function longint div_q(longint a, longint b);
      logic [127:0] n, d, q, r;
      bit           neg;
      neg = (a < 0) != (b < 0);
      n = 128'(a < 0 ? -a : a) << lds_pkg::FRAC_BITS;
      d = 128'(b < 0 ? -b : b);
      q = n / d;
      r = n % d;
      if (r >= d - r) q = q + 1;
      return from_mag(neg, q);
    endfunction

    function void note(lds_pkg::word_t m[9]);
      longint    d1, d2, d3, l21, l31, l32, y2, y3, z1, z2, z3, x0, x1;
      solution_t e;
      e = '{0, 0, 0, 1'b1};
      d1 = m[0];
      if (d1 != 0) begin
        l21 = div_q(m[1], d1);
        l31 = div_q(m[2], d1);
        d2 = sub_s(m[3], mul_q(mul_q(l21, l21), d1));
        if (d2 != 0) begin
          l32 = div_q(sub_s(m[4], mul_q(mul_q(l21, l31), d1)), d2);
          d3 = sub_s(m[5], add_s(mul_q(mul_q(l31, l31), d1), mul_q(mul_q(l32, l32), d2)));
          if (d3 != 0) begin
            y2 = sub_s(m[7], mul_q(l21, m[6]));
            y3 = sub_s(sub_s(m[8], mul_q(l31, m[6])), mul_q(l32, y2));
            z1 = div_q(m[6], d1);
            z2 = div_q(y2, d2);
            z3 = div_q(y3, d3);
            x1 = sub_s(z2, mul_q(l32, z3));
            x0 = sub_s(sub_s(z1, mul_q(l21, x1)), mul_q(l31, z3));
            e = '{lds_pkg::word_t'(x0), lds_pkg::word_t'(x1), lds_pkg::word_t'(z3), 1'b0};
          end
        end
      end
      pending.push_back(e);
    endfunction

    function void check(lds_pkg::word_t s0, lds_pkg::word_t s1, lds_pkg::word_t s2, logic f);
      solution_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h %h %b", s0, s1, s2, f);
        return;
      end
      e = pending.pop_front();
      if (e.s0 !== s0 || e.s1 !== s1 || e.s2 !== s2 || e.fault !== f) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                   e.s0, e.s1, e.s2, e.fault, s0, s1, s2, f);
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           push = 1'b0;
  logic           pop = 1'b0;
  logic           full, empty, out_pivot_fault;
  lds_pkg::word_t in_m[9];
  lds_pkg::word_t out_sol_0, out_sol_1, out_sol_2;

  solution_board board = new();
  int tx_idle = 0;
  int rx_stall = 0;
  int hold_req = 0;

  initial for (int i = 0; i < 9; i++) in_m[i] = '0;

  always #2 clk = ~clk;

  ldlt_solve_3x3_top dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_m_00(in_m[0]), .in_m_10(in_m[1]), .in_m_20(in_m[2]),
    .in_m_11(in_m[3]), .in_m_21(in_m[4]), .in_m_22(in_m[5]),
    .in_rhs_0(in_m[6]), .in_rhs_1(in_m[7]), .in_rhs_2(in_m[8]),
    .empty(empty), .pop(pop),
    .out_sol_0(out_sol_0), .out_sol_1(out_sol_1), .out_sol_2(out_sol_2),
    .out_pivot_fault(out_pivot_fault)
  );

  // receiver: check on the edge, then choose pop for the next cycle
  initial begin
    int hold;
    hold = 0;
    @(posedge clk);
    while (1) begin
      @(posedge clk);
      if (rst_n && pop && !empty) board.check(out_sol_0, out_sol_1, out_sol_2, out_pivot_fault);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  // called just after a rising edge; returns just after the accepting edge
  task automatic send(lds_pkg::word_t m[9]);
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    for (int i = 0; i < 9; i++) in_m[i] <= m[i];
    do @(posedge clk); while (full);
    board.note(m);
  endtask

  function automatic lds_pkg::word_t any_word();
    case ($urandom_range(5))
      0: return lds_pkg::WORD_MAX;
      1: return lds_pkg::WORD_MIN;
      2: return lds_pkg::word_t'($urandom_range(3)) - 1;
      default: return lds_pkg::word_t'($urandom);
    endcase
  endfunction

  // mostly diagonally dominant systems, some raw noise and forced zero pivots
  task automatic send_random();
    lds_pkg::word_t m[9];
    int             k;
    k = $urandom_range(99);
    for (int i = 0; i < 9; i++) m[i] = any_word();
    if (k < 70) begin
      for (int i = 0; i < 6; i++) begin
        if (i == 0 || i == 3 || i == 5) begin
          m[i] = lds_pkg::word_t'($urandom_range(32'h0100_0000, 32'h0000_1000));
          if ($urandom_range(3) == 0) m[i] = -m[i];
        end else begin
          m[i] = lds_pkg::word_t'($signed($urandom) >>> $urandom_range(22, 8));
        end
      end
      if ($urandom_range(1)) for (int i = 6; i < 9; i++) m[i] = m[i] >>> $urandom_range(12);
    end else if (k < 80) begin
      case ($urandom_range(2))
        0: m[0] = '0;
        1: begin
          m[0] = 32'sh0001_0000 << $urandom_range(3);
          m[1] = m[0] * $urandom_range(3);
          m[3] = (m[1] / m[0]) * m[1];
        end
        default: begin
          m[0] = 32'sh0001_0000; m[1] = '0; m[2] = '0;
          m[3] = 32'sh0002_0000; m[4] = '0; m[5] = '0;
        end
      endcase
    end
    send(m);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    lds_pkg::word_t m[9];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: identity, extremes, each pivot zero in turn
    m = '{32'sh0001_0000, 0, 0, 32'sh0001_0000, 0, 32'sh0001_0000,
          32'sh0001_0000, lds_pkg::WORD_MAX, lds_pkg::WORD_MIN};
    send(m);
    m = '{lds_pkg::WORD_MAX, lds_pkg::WORD_MAX, lds_pkg::WORD_MAX,
          lds_pkg::WORD_MAX, lds_pkg::WORD_MAX, lds_pkg::WORD_MAX,
          lds_pkg::WORD_MAX, lds_pkg::WORD_MAX, lds_pkg::WORD_MAX};
    send(m);
    m = '{lds_pkg::WORD_MIN, lds_pkg::WORD_MIN, lds_pkg::WORD_MIN,
          lds_pkg::WORD_MIN, lds_pkg::WORD_MIN, lds_pkg::WORD_MIN,
          lds_pkg::WORD_MIN, lds_pkg::WORD_MIN, lds_pkg::WORD_MIN};
    send(m);
    m = '{1, lds_pkg::WORD_MAX, lds_pkg::WORD_MIN, 1, -1, 1, lds_pkg::WORD_MAX, 1, -1};
    send(m);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send(m);
    m = '{0, 5, 6, 7, 8, 9, 1, 2, 3};
    send(m);
    m = '{32'sh0001_0000, 32'sh0002_0000, 0, 32'sh0004_0000, 1, 2, 3, 4, 5};
    send(m);
    m = '{32'sh0001_0000, 0, 0, 32'sh0002_0000, 0, 0, 7, 8, 9};
    send(m);
    m = '{32'sh0004_0000, 32'sh0001_0000, 32'sh0000_8000, 32'sh0003_0000,
          -32'sh0000_4000, 32'sh0002_0000, 32'sh0010_0000, -32'sh0003_0000, 32'sh0000_0001};
    send(m);
    m = '{-32'sh0002_0000, 32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0001_0000,
          -32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};
    send(m);
    m = '{1, 0, 0, 1, 0, 1, lds_pkg::WORD_MAX, lds_pkg::WORD_MIN, lds_pkg::WORD_MAX};
    send(m);
    m = '{lds_pkg::WORD_MAX, 1, 1, lds_pkg::WORD_MAX, 1, lds_pkg::WORD_MAX, 1, 1, 1};
    send(m);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 63 : 7) : 0;
      rx_stall = (ph == 2) ? 63 : (ph == 3) ? 7 : 0;
      // long receiver hold so the result queue fills and the back pipeline holds
      if (ph == 0) hold_req = 300;
      repeat (110) send_random();
      drain();
    end
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
